FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the converter core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define ICPC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) (expr)) else $error(msg);

// Checked only while reset is released.
`define ICPC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/icpc_pkg.sv
// Package with constants, types and character helpers of the converter core.
package icpc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic       emit;
        logic       finish;
        logic [7:0] data;
        out_kind_t  kind;
    } res_req_t;

    function automatic logic is_operand(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    // Precedence offset by one so that it stays unsigned: 0 stands for -1.
    function automatic logic [2:0] prec(input logic [7:0] c);
        logic [2:0] p;
        p = 3'd0;
        if (c == CH_CARET) begin
            p = 3'd4;
        end
        else if ((c == CH_STAR) || (c == CH_SLASH)) begin
            p = 3'd3;
        end
        else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            p = 3'd2;
        end
        return p;
    endfunction

endpackage

FILE: rtl/core/infix_to_postfix_converter_core.sv
// Top level of the infix-to-postfix converter core.
// Input channel: one ASCII character per transfer (ch), with end_of_expr set on
// the last character of an expression. Output channel: one postfix result per
// transfer: out_char, out_kind (character, end of expression, or error) and
// run_last, which is set on the last result caused by an input transfer.
// An item is evaluated and then finished; every stack entry that it emits
// passes through a wait state before evaluation resumes, while dropping the
// matching open parenthesis needs no wait state. An item that ends the
// expression then flushes the stack, each entry through a wait state, and
// emits the end marker. The single stack RAM read port is registered, so
// each emitted pop waits for the new top of stack. The block accepts no new
// character while an item is being worked on. Results pass through a hold
// stage and an output register; a result moves on when the next one or the
// end of the item is produced. When the receiver stalls, the output and
// hold stages fill and the sequencer waits. Reset empties the stack and drops
// any result not yet transferred; the stack RAM itself is not cleared.
module infix_to_postfix_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       end_of_expr,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic [1:0] out_kind,
    output logic       run_last
);

    logic                        wr_en;
    logic [icpc_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                  wr_data;
    logic [icpc_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  top;
    icpc_pkg::res_req_t          req;
    logic                        req_ready;

    icpc_ram #(
        .DATA_W (8),
        .DEPTH  (icpc_pkg::STACK_DEPTH),
        .ADDR_W (icpc_pkg::ADDR_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (top)
    );

    icpc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .end_of_expr (end_of_expr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .top         (top),
        .req         (req),
        .req_ready   (req_ready)
    );

    icpc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .out_kind  (out_kind),
        .run_last  (run_last)
    );

endmodule

FILE: rtl/core/icpc_ram.sv
// Generic single-port-write, registered-read RAM.
module icpc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/icpc_outbuf.sv
// Result buffer: one hold stage that finds the last result, then the output register.
`include "assert_macros.svh"

module icpc_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  icpc_pkg::res_req_t req,
    output logic              req_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic [1:0]        out_kind,
    output logic              run_last
);

    logic                hold_valid_reg, hold_valid_next;
    logic [7:0]          hold_data_reg, hold_data_next;
    icpc_pkg::out_kind_t hold_kind_reg, hold_kind_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg, out_char_next;
    icpc_pkg::out_kind_t out_kind_reg, out_kind_next;
    logic                run_last_reg, run_last_next;
    logic                slot_free;
    logic                fire;

    assign slot_free = !out_valid_reg || out_ready;
    assign req_ready = !hold_valid_reg || slot_free;
    assign fire      = (req.emit || req.finish) && req_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        hold_kind_next  = hold_kind_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        out_kind_next   = out_kind_reg;
        run_last_next   = run_last_reg;
        if (fire)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = hold_data_reg;
                out_kind_next  = hold_kind_reg;
                run_last_next  = req.finish;
            end
            hold_valid_next = req.emit;
            hold_data_next  = req.data;
            hold_kind_next  = req.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
        hold_kind_reg <= hold_kind_next;
        out_char_reg  <= out_char_next;
        out_kind_reg  <= out_kind_next;
        run_last_reg  <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_kind  = out_kind_reg;
    assign run_last  = run_last_reg;

    `ICPC_ASSERT_RUN(a_finish_empties_hold, (req.finish && req_ready) |=> !hold_valid_reg,
        "hold stage not empty after the item finished")
    `ICPC_ASSERT_RUN(a_last_moves_hold, (req.finish && req_ready && hold_valid_reg) |=>
        (out_valid_reg && run_last_reg), "last result of an item not marked")

endmodule

FILE: rtl/core/icpc_ctrl.sv
// Sequencer that walks the operator stack one entry at a time.
`include "assert_macros.svh"

module icpc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   ch,
    input  logic                         end_of_expr,
    output logic                         wr_en,
    output logic [icpc_pkg::ADDR_W-1:0]  wr_addr,
    output logic [7:0]                   wr_data,
    output logic [icpc_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [7:0]                   top,
    output icpc_pkg::res_req_t           req,
    input  logic                         req_ready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_WAIT_E = 6'b000100,
        S_FLUSH  = 6'b001000,
        S_WAIT_F = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [icpc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [7:0]                   ch_reg, ch_next;
    logic                         eoe_reg, eoe_next;
    logic [icpc_pkg::CNT_W-1:0]   count_m1;
    logic                         empty;
    logic                         full;
    state_t                       post_state;

    assign count_m1   = count_reg - icpc_pkg::CNT_W'(1);
    assign rd_addr    = count_m1[icpc_pkg::ADDR_W-1:0];
    assign wr_addr    = count_reg[icpc_pkg::ADDR_W-1:0];
    assign wr_data    = ch_reg;
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == icpc_pkg::CNT_W'(icpc_pkg::STACK_DEPTH));
    assign post_state = eoe_reg ? S_WAIT_F : S_DONE;
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ch_next    = ch_reg;
        eoe_next   = eoe_reg;
        wr_en      = 1'b0;
        req        = '0;
        req.kind   = icpc_pkg::KIND_CHAR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = ch;
                    eoe_next   = end_of_expr;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (icpc_pkg::is_operand(ch_reg))
                begin
                    req.emit = 1'b1;
                    req.data = ch_reg;
                    if (req_ready)
                    begin
                        state_next = post_state;
                    end
                end
                else if (ch_reg == icpc_pkg::CH_RPAREN)
                begin
                    if (empty)
                    begin
                        req.emit = 1'b1;
                        req.kind = icpc_pkg::KIND_ERR;
                        if (req_ready)
                        begin
                            state_next = post_state;
                        end
                    end
                    else if (top == icpc_pkg::CH_LPAREN)
                    begin
                        count_next = count_m1;
                        state_next = post_state;
                    end
                    else
                    begin
                        req.emit = 1'b1;
                        req.data = top;
                        if (req_ready)
                        begin
                            count_next = count_m1;
                            state_next = S_WAIT_E;
                        end
                    end
                end
                else if (ch_reg != icpc_pkg::CH_LPAREN && !empty &&
                         icpc_pkg::prec(ch_reg) <= icpc_pkg::prec(top))
                begin
                    req.emit = 1'b1;
                    req.data = top;
                    if (req_ready)
                    begin
                        count_next = count_m1;
                        state_next = S_WAIT_E;
                    end
                end
                else if (full)
                begin
                    req.emit = 1'b1;
                    req.kind = icpc_pkg::KIND_ERR;
                    if (req_ready)
                    begin
                        state_next = post_state;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + icpc_pkg::CNT_W'(1);
                    state_next = post_state;
                end
            end
            S_WAIT_E:
            begin
                state_next = S_EVAL;
            end
            S_FLUSH:
            begin
                req.emit = 1'b1;
                if (!empty)
                begin
                    req.data = top;
                    if (req_ready)
                    begin
                        count_next = count_m1;
                        state_next = S_WAIT_F;
                    end
                end
                else
                begin
                    req.kind = icpc_pkg::KIND_END;
                    if (req_ready)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WAIT_F:
            begin
                state_next = S_FLUSH;
            end
            S_DONE:
            begin
                req.finish = 1'b1;
                if (req_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        eoe_reg <= eoe_next;
    end

    `ICPC_ASSERT_ALWAYS(a_count_bound,
        !rst_n || (count_reg <= icpc_pkg::CNT_W'(icpc_pkg::STACK_DEPTH)), "stack count above depth")
    `ICPC_ASSERT_RUN(a_no_push_when_full, wr_en |-> !full, "push onto a full stack")
    `ICPC_ASSERT_RUN(a_count_step, (count_reg == $past(count_reg)) ||
        (count_reg == $past(count_reg) + icpc_pkg::CNT_W'(1)) ||
        (count_reg == $past(count_reg) - icpc_pkg::CNT_W'(1)), "stack count jumped")

endmodule
